@@ sv/nrmc_pkg.sv @@
// Shared types, constants and the power-of-ten table for the RMC position extractor.
// No dependencies; every other file of the block but nrmc_in_stage imports this package.
`default_nettype none

package nrmc_pkg;

  localparam int FRAC_DIGITS_DEF = 5;
  localparam int FRAC_W = 3;
  localparam int ACC_W = 31;
  localparam int LAT_W = 30;
  localparam int LON_W = 31;
  localparam int POW_W = 20;
  localparam int SCL_W = ACC_W + POW_W;
  localparam int CNT_W = 3;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
  localparam logic [LAT_W-1:0] LAT_MAX = 30'd900000000;
  localparam logic [LON_W-1:0] LON_MAX = 31'd1800000000;

  localparam logic [CNT_W-1:0] LAT_COMMA = 3'd3;
  localparam logic [CNT_W-1:0] LON_COMMA = 3'd5;
  localparam logic [CNT_W-1:0] COMMA_MAX = 3'd7;
  localparam logic [CNT_W-1:0] FIRST_COMMA = 3'd1;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef struct packed {
    logic [LAT_W-1:0] lat;
    logic [LON_W-1:0] lon;
    logic [LAT_W-1:0] prev_lat;
    logic [LON_W-1:0] prev_lon;
    logic             pair_valid;
  } fix_t;

  function automatic logic [POW_W-1:0] pow10(input logic [FRAC_W-1:0] n);
    logic [POW_W-1:0] p;
    case (n)
      3'd0: p = 20'd1;
      3'd1: p = 20'd10;
      3'd2: p = 20'd100;
      3'd3: p = 20'd1000;
      3'd4: p = 20'd10000;
      3'd5: p = 20'd100000;
      3'd6: p = 20'd1000000;
      default: p = 20'd1;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

@@ sv/nmea_rmc_position_extractor.sv @@
// Top level of the RMC position extractor: input byte register, parser and result register.
// Depends on nrmc_pkg, nrmc_in_stage, nrmc_core and nrmc_out_stage.
`default_nettype none

// The block takes one byte of a GPS serial stream per beat and may accept a new byte in every
// cycle. A byte is parsed in the cycle after it is accepted unless it is a newline that must
// wait; a newline that ends a valid sentence places one result beat in the result register at
// the end of the cycle in which it is parsed, after passing the byte register. The rate is set
// by the byte register and the parser state, which advance once per byte; a newline waits in the
// byte register only while the result register still holds a beat that has not been taken.
// Latitude and longitude are reported scaled by ten to the FRAC_DIGITS, together with the
// previous fix and a flag that is set when both previous values are nonzero.
module nmea_rmc_position_extractor #(
  parameter int FRAC_DIGITS = nrmc_pkg::FRAC_DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 rx_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [nrmc_pkg::LAT_W-1:0] latitude,
  output logic [nrmc_pkg::LON_W-1:0] longitude,
  output logic [nrmc_pkg::LAT_W-1:0] previous_latitude,
  output logic [nrmc_pkg::LON_W-1:0] previous_longitude,
  output logic                       pair_valid
);

  import nrmc_pkg::*;

  logic       byte_valid;
  logic [7:0] byte_q;
  logic       step;
  logic       emit;
  logic       out_free;
  logic       load;
  fix_t       fix;
  fix_t       fix_q;

  assign step = byte_valid && (!emit || out_free);
  assign load = step && emit;

  nrmc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .rx_byte    (rx_byte),
    .take       (step),
    .in_ready   (in_ready),
    .byte_valid (byte_valid),
    .byte_q     (byte_q)
  );

  nrmc_core #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .rx_byte (byte_q),
    .step    (step),
    .emit    (emit),
    .fix     (fix)
  );

  nrmc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .fix_in    (fix),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (out_free),
    .fix_q     (fix_q)
  );

  assign latitude           = fix_q.lat;
  assign longitude          = fix_q.lon;
  assign previous_latitude  = fix_q.prev_lat;
  assign previous_longitude = fix_q.prev_lon;
  assign pair_valid         = fix_q.pair_valid;

  a_pair_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pair_valid == ((previous_latitude != '0) && (previous_longitude != '0))))
    else $error("pair_valid disagrees with the previous fix");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((latitude <= LAT_MAX) && (longitude <= LON_MAX)))
    else $error("reported position exceeds its saturation limit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !load)
    else $error("result register loaded while its beat is still waiting");

endmodule

`default_nettype wire

@@ sv/nrmc_in_stage.sv @@
// Input register of the RMC position extractor: holds one received byte until the parser takes it.
// Does not depend on nrmc_pkg; plain byte storage.
`default_nettype none

module nrmc_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output logic       in_ready,
  output logic       byte_valid,
  output logic [7:0] byte_q
);

  assign in_ready = !byte_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= rx_byte;
    end
  end

endmodule

`default_nettype wire

@@ sv/nrmc_core.sv @@
// Sentence parser and field converter of the RMC position extractor.
// Depends on nrmc_pkg for constants, the fix_t result type and the power-of-ten table.
`default_nettype none

module nrmc_core #(
  parameter int FRAC_DIGITS = nrmc_pkg::FRAC_DIGITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    rx_byte,
  input  logic          step,
  output logic          emit,
  output nrmc_pkg::fix_t fix
);

  import nrmc_pkg::*;

  typedef enum logic [7:0] {
    PH_HUNT = 8'b0000_0001,
    PH_G    = 8'b0000_0010,
    PH_P    = 8'b0000_0100,
    PH_R    = 8'b0000_1000,
    PH_M    = 8'b0001_0000,
    PH_C    = 8'b0010_0000,
    PH_SKIP = 8'b0100_0000,
    PH_BODY = 8'b1000_0000
  } phase_t;

  phase_t             phase, phase_next;
  logic [CNT_W-1:0]   comma_count, comma_count_next;
  logic [ACC_W-1:0]   accumulator, accumulator_next;
  logic               point_seen, point_seen_next;
  logic [FRAC_W-1:0]  fraction_count, fraction_count_next;
  logic               field_stopped, field_stopped_next;
  logic [LAT_W-1:0]   latitude_hold, latitude_hold_next;
  logic [LON_W-1:0]   longitude_hold, longitude_hold_next;
  logic [LAT_W-1:0]   last_latitude, last_latitude_next;
  logic [LON_W-1:0]   last_longitude, last_longitude_next;

  logic               is_digit;
  logic               in_field;
  logic [ACC_W+3:0]   acc_ten;
  logic [ACC_W-1:0]   acc_digit;
  logic [POW_W-1:0]   scale;
  logic [SCL_W-1:0]   scaled;
  logic [LAT_W-1:0]   lat_scaled, lat_fin;
  logic [LON_W-1:0]   lon_scaled, lon_fin;

  assign is_digit = rx_byte inside {[CH_ZERO:CH_NINE]};
  assign in_field = ((comma_count == LAT_COMMA) || (comma_count == LON_COMMA)) && !field_stopped;

  assign acc_ten = ((ACC_W+4)'(accumulator) << 3) + ((ACC_W+4)'(accumulator) << 1)
                 + (ACC_W+4)'(rx_byte[3:0]);
  assign acc_digit = (acc_ten > (ACC_W+4)'(ACC_MAX)) ? ACC_MAX : acc_ten[ACC_W-1:0];

  assign scale  = pow10(FRAC_W'(FRAC_DIGITS) - fraction_count);
  assign scaled = SCL_W'(accumulator) * SCL_W'(scale);

  assign lat_scaled = (scaled > SCL_W'(LAT_MAX)) ? LAT_MAX : scaled[LAT_W-1:0];
  assign lon_scaled = (scaled > SCL_W'(LON_MAX)) ? LON_MAX : scaled[LON_W-1:0];
  assign lat_fin = (comma_count == LAT_COMMA) ? lat_scaled : latitude_hold;
  assign lon_fin = (comma_count == LON_COMMA) ? lon_scaled : longitude_hold;

  assign emit = ((phase == PH_SKIP) || (phase == PH_BODY)) && (rx_byte == CH_NL);

  always_comb begin
    fix.lat        = (phase == PH_BODY) ? lat_fin : latitude_hold;
    fix.lon        = (phase == PH_BODY) ? lon_fin : longitude_hold;
    fix.prev_lat   = last_latitude;
    fix.prev_lon   = last_longitude;
    fix.pair_valid = (last_latitude != '0) && (last_longitude != '0);
  end

  always_comb begin
    phase_next          = phase;
    comma_count_next    = comma_count;
    accumulator_next    = accumulator;
    point_seen_next     = point_seen;
    fraction_count_next = fraction_count;
    field_stopped_next  = field_stopped;
    latitude_hold_next  = latitude_hold;
    longitude_hold_next = longitude_hold;
    last_latitude_next  = last_latitude;
    last_longitude_next = last_longitude;
    case (phase)
      PH_HUNT: begin
        if (rx_byte == CH_DOLLAR) begin
          phase_next = PH_G;
        end
      end
      PH_G: phase_next = (rx_byte == CH_G) ? PH_P : PH_HUNT;
      PH_P: phase_next = (rx_byte == CH_P) ? PH_R : PH_HUNT;
      PH_R: phase_next = (rx_byte == CH_R) ? PH_M : PH_HUNT;
      PH_M: phase_next = (rx_byte == CH_M) ? PH_C : PH_HUNT;
      PH_C: begin
        if (rx_byte == CH_C) begin
          phase_next          = PH_SKIP;
          comma_count_next    = '0;
          accumulator_next    = '0;
          point_seen_next     = 1'b0;
          fraction_count_next = '0;
          field_stopped_next  = 1'b0;
          latitude_hold_next  = '0;
          longitude_hold_next = '0;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_SKIP: begin
        if (rx_byte == CH_NL) begin
          last_latitude_next  = latitude_hold;
          last_longitude_next = longitude_hold;
          phase_next          = PH_HUNT;
        end else begin
          comma_count_next = FIRST_COMMA;
          phase_next       = PH_BODY;
        end
      end
      PH_BODY: begin
        if (rx_byte == CH_NL) begin
          latitude_hold_next  = lat_fin;
          longitude_hold_next = lon_fin;
          last_latitude_next  = lat_fin;
          last_longitude_next = lon_fin;
          phase_next          = PH_HUNT;
        end else if (rx_byte == CH_COMMA) begin
          latitude_hold_next  = lat_fin;
          longitude_hold_next = lon_fin;
          if (comma_count < COMMA_MAX) begin
            comma_count_next = comma_count + 1'b1;
          end
          accumulator_next    = '0;
          point_seen_next     = 1'b0;
          fraction_count_next = '0;
          field_stopped_next  = 1'b0;
        end else if (in_field) begin
          if (is_digit) begin
            if (!point_seen) begin
              accumulator_next = acc_digit;
            end else if (fraction_count < FRAC_W'(FRAC_DIGITS)) begin
              accumulator_next    = acc_digit;
              fraction_count_next = fraction_count + 1'b1;
            end
          end else if ((rx_byte == CH_POINT) && !point_seen) begin
            point_seen_next = 1'b1;
          end else begin
            field_stopped_next = 1'b1;
          end
        end
      end
      default: phase_next = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      comma_count    <= '0;
      accumulator    <= '0;
      point_seen     <= 1'b0;
      fraction_count <= '0;
      field_stopped  <= 1'b0;
      latitude_hold  <= '0;
      longitude_hold <= '0;
      last_latitude  <= '0;
      last_longitude <= '0;
    end else if (step) begin
      phase          <= phase_next;
      comma_count    <= comma_count_next;
      accumulator    <= accumulator_next;
      point_seen     <= point_seen_next;
      fraction_count <= fraction_count_next;
      field_stopped  <= field_stopped_next;
      latitude_hold  <= latitude_hold_next;
      longitude_hold <= longitude_hold_next;
      last_latitude  <= last_latitude_next;
      last_longitude <= last_longitude_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/nrmc_out_stage.sv @@
// Result register of the RMC position extractor: holds one fix until the consumer takes the beat.
// Depends on nrmc_pkg for the fix_t result type.
`default_nettype none

module nrmc_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  nrmc_pkg::fix_t fix_in,
  input  logic           out_ready,
  output logic           out_valid,
  output logic           free,
  output nrmc_pkg::fix_t fix_q
);

  import nrmc_pkg::*;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fix_q <= fix_in;
    end
  end

endmodule

`default_nettype wire
